>>> rtl/core/wam_pkg.sv
// Shared types and constants of the weekly alarm matcher.
package wam_pkg;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_ALARM   = 2'd1;
    localparam logic [1:0] REQ_HOLIDAY = 2'd2;

    localparam logic [3:0] DAY_SUNDAY    = 4'd0;
    localparam logic [3:0] DAY_SATURDAY  = 4'd6;
    localparam logic [3:0] RULE_WORKDAY  = 4'd7;
    localparam logic [3:0] RULE_WEEKEND  = 4'd8;
    localparam logic [3:0] RULE_EVERYDAY = 4'd9;
    localparam logic [3:0] RULE_HOLIDAY  = 4'd10;

    localparam logic [4:0]  LAST_HOUR        = 5'd23;
    localparam logic [5:0]  MINUTES_PER_HOUR = 6'd60;
    localparam logic [15:0] EPOCH_YEAR       = 16'd1970;
    localparam logic [7:0]  LAST_MINUTE_INIT = 8'hF0;
    localparam logic [4:0]  MAX_RESULTS      = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOL,
        ST_ALM,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic idle;
        logic hol_read;
        logic alm_read;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic tick_go;
        logic hol_last;
        logic alm_last;
    } status_t;

endpackage

>>> rtl/core/weekly_alarm_matcher.sv
// Top level of the weekly alarm matcher: controller and datapath.
//
// An item is taken at a rising edge where start is high and busy is low.
// req_type selects a tick, an alarm slot write or a holiday slot write.
// Slot writes and ticks that are rejected (hour above 23, year 1970, or
// the same minute as the last accepted tick) leave busy low.
// A valid tick with alarms on raises busy while the holiday table is
// walked one entry a cycle, then the alarm table, each through a single
// registered read port, then through a drain state and a flush state.
// The table walks set the rate.
// Each firing alarm index appears on alarm_index for one cycle with
// result_valid high, in ascending slot order, at most sixteen per tick;
// last marks the final item of the tick. The last item appears in the cycle
// after busy falls. The receiver cannot stall the result items.
// The user must write the alarms_on register through cfg_we and cfg_wdata only
// while idle; the block itself does not enforce it. Reset clears all enable
// and valid bits, sets alarms_on and forgets the last minute seen.
module weekly_alarm_matcher
#(
    parameter int ALARM_SLOTS   = 16,
    parameter int HOLIDAY_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic [1:0]  req_type,
    input  logic [3:0]  slot,
    input  logic        entry_enable,
    input  logic [3:0]  day_code,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [4:0]  day_of_month,
    input  logic [3:0]  month,
    input  logic [15:0] year,
    input  logic [4:0]  end_day,
    input  logic [3:0]  end_month,
    input  logic [7:0]  end_year_offset,
    output logic        result_valid,
    output logic [3:0]  alarm_index,
    output logic        last
);

    wam_pkg::cmd_t    cmd;
    wam_pkg::status_t status;

    assign busy = ~cmd.idle;

    wam_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    wam_datapath
    #(
        .ALARM_SLOTS   (ALARM_SLOTS),
        .HOLIDAY_SLOTS (HOLIDAY_SLOTS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_type        (req_type),
        .slot            (slot),
        .entry_enable    (entry_enable),
        .day_code        (day_code),
        .hour            (hour),
        .minute          (minute),
        .day_of_month    (day_of_month),
        .month           (month),
        .year            (year),
        .end_day         (end_day),
        .end_month       (end_month),
        .end_year_offset (end_year_offset),
        .result_valid    (result_valid),
        .alarm_index     (alarm_index),
        .last            (last)
    );

endmodule

>>> rtl/core/wam_ctrl.sv
// Controller state machine that sequences the holiday and alarm table walks.
module wam_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  wam_pkg::status_t  status,
    output wam_pkg::cmd_t     cmd
);

    wam_pkg::state_t state_reg;
    wam_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wam_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wam_pkg::ST_IDLE:
            begin
                if (status.tick_go)
                begin
                    state_next = wam_pkg::ST_HOL;
                end
            end
            wam_pkg::ST_HOL:
            begin
                if (status.hol_last)
                begin
                    state_next = wam_pkg::ST_ALM;
                end
            end
            wam_pkg::ST_ALM:
            begin
                if (status.alm_last)
                begin
                    state_next = wam_pkg::ST_DRAIN;
                end
            end
            wam_pkg::ST_DRAIN:
            begin
                state_next = wam_pkg::ST_FLUSH;
            end
            wam_pkg::ST_FLUSH:
            begin
                state_next = wam_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wam_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            wam_pkg::ST_IDLE:  cmd.idle     = 1'b1;
            wam_pkg::ST_HOL:   cmd.hol_read = 1'b1;
            wam_pkg::ST_ALM:   cmd.alm_read = 1'b1;
            wam_pkg::ST_DRAIN: cmd           = '0;
            wam_pkg::ST_FLUSH: cmd.flush    = 1'b1;
            default:           cmd           = '0;
        endcase
    end

endmodule

>>> rtl/core/wam_datapath.sv
// Datapath: slot tables, tick registers, holiday and alarm matching, result register.
module wam_datapath
#(
    parameter int ALARM_SLOTS   = 16,
    parameter int HOLIDAY_SLOTS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  wam_pkg::cmd_t     cmd,
    output wam_pkg::status_t  status,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [1:0]        req_type,
    input  logic [3:0]        slot,
    input  logic              entry_enable,
    input  logic [3:0]        day_code,
    input  logic [4:0]        hour,
    input  logic [5:0]        minute,
    input  logic [4:0]        day_of_month,
    input  logic [3:0]        month,
    input  logic [15:0]       year,
    input  logic [4:0]        end_day,
    input  logic [3:0]        end_month,
    input  logic [7:0]        end_year_offset,
    output logic              result_valid,
    output logic [3:0]        alarm_index,
    output logic              last
);

    localparam int AAW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int HAW = (HOLIDAY_SLOTS > 1) ? $clog2(HOLIDAY_SLOTS) : 1;

    // Tables. Enable and valid bits are flip-flops cleared by reset.
    logic [10:0] alarm_time_mem  [ALARM_SLOTS];
    logic [3:0]  alarm_rule_mem  [ALARM_SLOTS];
    logic [24:0] hol_start_mem   [HOLIDAY_SLOTS];
    logic [16:0] hol_end_mem     [HOLIDAY_SLOTS];
    logic [ALARM_SLOTS-1:0]   alarm_en_reg;
    logic [HOLIDAY_SLOTS-1:0] hol_valid_reg;

    logic        alarms_on_reg;
    logic [7:0]  last_minute_reg;

    // Tick item captured when a valid tick with alarms on is taken.
    logic [10:0] tod_reg;
    logic        tod_ok_reg;
    logic [3:0]  wday_reg;
    logic [25:0] today_reg;

    logic [HAW-1:0] hol_cnt_reg;
    logic [AAW-1:0] alm_cnt_reg;

    // Registered table reads.
    logic           hol_eval_reg;
    logic           hv_rd_reg;
    logic [24:0]    hs_rd_reg;
    logic [16:0]    he_rd_reg;
    logic           alm_eval_reg;
    logic           ae_rd_reg;
    logic [10:0]    at_rd_reg;
    logic [3:0]     ar_rd_reg;
    logic [AAW-1:0] ai_rd_reg;

    logic       hol_reg;
    logic       pend_vld_reg;
    logic       pend_vld_next;
    logic [3:0] pend_idx_reg;
    logic [3:0] pend_idx_next;
    logic [4:0] hit_cnt_reg;
    logic [4:0] hit_cnt_next;
    logic       out_vld_reg;
    logic       out_vld_next;
    logic [3:0] out_idx_reg;
    logic [3:0] out_idx_next;
    logic       out_last_reg;
    logic       out_last_next;

    logic           accept;
    logic           tick_ok;
    logic           tick_valid;
    logic           wr_alarm;
    logic           wr_hol;
    logic [AAW-1:0] slot_a;
    logic [HAW-1:0] slot_h;
    logic [10:0]    tod_in;
    logic           hol_match;
    logic           rule_ok;
    logic           hit;

    logic [4:0]  sd;
    logic [3:0]  sm;
    logic [15:0] sy;
    logic [4:0]  ed;
    logic [3:0]  em;
    logic [7:0]  eoff;
    logic [25:0] key_lo;
    logic [25:0] key_hi;

    assign accept     = start & cmd.idle;
    assign tick_ok    = (hour <= wam_pkg::LAST_HOUR)
                        && ({2'b00, minute} != last_minute_reg)
                        && (year != wam_pkg::EPOCH_YEAR);
    assign tick_valid = accept && (req_type == wam_pkg::REQ_TICK) && tick_ok;
    assign wr_alarm   = accept && (req_type == wam_pkg::REQ_ALARM)
                        && (int'(slot) < ALARM_SLOTS);
    assign wr_hol     = accept && (req_type == wam_pkg::REQ_HOLIDAY)
                        && (int'(slot) < HOLIDAY_SLOTS);
    assign slot_a     = AAW'(slot);
    assign slot_h     = HAW'(slot);
    assign tod_in     = 11'(hour) * 11'(wam_pkg::MINUTES_PER_HOUR) + 11'(minute);

    assign status.tick_go  = tick_valid & alarms_on_reg;
    assign status.hol_last = (hol_cnt_reg == HAW'(HOLIDAY_SLOTS - 1));
    assign status.alm_last = (alm_cnt_reg == AAW'(ALARM_SLOTS - 1));

    // Table writes.
    always_ff @(posedge clk)
    begin
        if (wr_alarm)
        begin
            alarm_time_mem[slot_a] <= 11'(hour) * 11'(wam_pkg::MINUTES_PER_HOUR)
                                      + 11'(minute);
            alarm_rule_mem[slot_a] <= day_code;
        end
        if (wr_hol)
        begin
            hol_start_mem[slot_h] <= {year, month, day_of_month};
            hol_end_mem[slot_h]   <= {end_year_offset, end_month, end_day};
        end
    end

    // Table reads, one entry per cycle during each walk; tick capture; output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.hol_read)
        begin
            hs_rd_reg <= hol_start_mem[hol_cnt_reg];
            he_rd_reg <= hol_end_mem[hol_cnt_reg];
            hv_rd_reg <= hol_valid_reg[hol_cnt_reg];
        end
        if (cmd.alm_read)
        begin
            at_rd_reg <= alarm_time_mem[alm_cnt_reg];
            ar_rd_reg <= alarm_rule_mem[alm_cnt_reg];
            ae_rd_reg <= alarm_en_reg[alm_cnt_reg];
            ai_rd_reg <= alm_cnt_reg;
        end
        if (status.tick_go)
        begin
            tod_reg    <= tod_in;
            tod_ok_reg <= (minute < wam_pkg::MINUTES_PER_HOUR);
            wday_reg   <= day_code;
            today_reg  <= {1'b0, year, month, day_of_month};
        end
        alarm_index <= out_idx_reg;
        last        <= out_last_reg;
    end

    // Holiday match on the entry read in the previous cycle.
    always_comb
    begin
        sd     = hs_rd_reg[4:0];
        sm     = hs_rd_reg[8:5];
        sy     = hs_rd_reg[24:9];
        ed     = he_rd_reg[4:0];
        em     = he_rd_reg[8:5];
        eoff   = he_rd_reg[16:9];
        key_lo = {1'b0, sy, sm, sd};
        key_hi = {17'(sy) + 17'(eoff), em, ed};
        hol_match = 1'b0;
        if ((today_reg[4:0] == sd) && (today_reg[8:5] == sm)
            && ((sy == 16'd0) || (today_reg[24:9] == sy)))
        begin
            hol_match = 1'b1;
        end
        if ((ed != 5'd0) && (em != 4'd0) && (today_reg >= key_lo) && (today_reg <= key_hi))
        begin
            hol_match = 1'b1;
        end
    end

    // Day rule of the alarm entry read in the previous cycle.
    always_comb
    begin
        if (hol_reg)
        begin
            rule_ok = (ar_rd_reg == wam_pkg::RULE_HOLIDAY);
        end
        else
        begin
            rule_ok = (ar_rd_reg == wday_reg)
                || (ar_rd_reg == wam_pkg::RULE_EVERYDAY)
                || ((ar_rd_reg == wam_pkg::RULE_WORKDAY) && (wday_reg > wam_pkg::DAY_SUNDAY)
                    && (wday_reg < wam_pkg::DAY_SATURDAY))
                || ((ar_rd_reg == wam_pkg::RULE_WEEKEND)
                    && ((wday_reg == wam_pkg::DAY_SUNDAY)
                        || (wday_reg == wam_pkg::DAY_SATURDAY)));
        end
    end

    // A stored time counts as a match only when the tick minute is below sixty.
    assign hit = alm_eval_reg && ae_rd_reg && tod_ok_reg && (at_rd_reg == tod_reg) && rule_ok
                 && (hit_cnt_reg < wam_pkg::MAX_RESULTS);

    // One hit is held back so that the final one of the tick can carry last.
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        out_vld_next  = 1'b0;
        out_idx_next  = pend_idx_reg;
        out_last_next = 1'b0;
        if (status.tick_go)
        begin
            pend_vld_next = 1'b0;
            hit_cnt_next  = 5'd0;
        end
        else if (hit)
        begin
            out_vld_next  = pend_vld_reg;
            pend_vld_next = 1'b1;
            pend_idx_next = 4'(ai_rd_reg);
            hit_cnt_next  = 5'(hit_cnt_reg + 5'd1);
        end
        else if (cmd.flush && pend_vld_reg)
        begin
            out_vld_next  = 1'b1;
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_en_reg    <= '0;
            hol_valid_reg   <= '0;
            alarms_on_reg   <= 1'b1;
            last_minute_reg <= wam_pkg::LAST_MINUTE_INIT;
            hol_cnt_reg     <= '0;
            alm_cnt_reg     <= '0;
            hol_eval_reg    <= 1'b0;
            alm_eval_reg    <= 1'b0;
            hol_reg         <= 1'b0;
            pend_vld_reg    <= 1'b0;
            hit_cnt_reg     <= '0;
            out_vld_reg     <= 1'b0;
            result_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                alarms_on_reg <= cfg_wdata;
            end
            if (wr_alarm)
            begin
                alarm_en_reg[slot_a] <= entry_enable;
            end
            if (wr_hol)
            begin
                hol_valid_reg[slot_h] <= entry_enable;
            end
            if (tick_valid)
            begin
                last_minute_reg <= {2'b00, minute};
            end
            if (status.tick_go)
            begin
                hol_cnt_reg <= '0;
                alm_cnt_reg <= '0;
                hol_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.hol_read)
                begin
                    hol_cnt_reg <= HAW'(hol_cnt_reg + 1'b1);
                end
                if (cmd.alm_read)
                begin
                    alm_cnt_reg <= AAW'(alm_cnt_reg + 1'b1);
                end
                if (hol_eval_reg && hv_rd_reg && hol_match)
                begin
                    hol_reg <= 1'b1;
                end
            end
            hol_eval_reg <= cmd.hol_read;
            alm_eval_reg <= cmd.alm_read;
            pend_vld_reg <= pend_vld_next;
            hit_cnt_reg  <= hit_cnt_next;
            out_vld_reg  <= out_vld_next;
            result_valid <= out_vld_reg;
        end
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the weekly alarm matcher, with its own prediction of the block.
`timescale 1ns / 1ps

module tb;
    import wam_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // How a directed row is checked: no item, one fixed item, or by prediction.
    localparam logic [1:0] CHK_NONE  = 2'd0;
    localparam logic [1:0] CHK_ONE   = 2'd1;
    localparam logic [1:0] CHK_MODEL = 2'd2;

    localparam int DIR_ROWS     = 25;
    localparam int SETTLE_TICKS = 40;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  slot;
        logic        entry_enable;
        logic [3:0]  day_code;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [15:0] year;
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [7:0]  end_year_offset;
    } request_t;

    typedef struct packed {
        logic [1:0] chk;
        logic [3:0] fixed_idx;
        request_t   it;
    } dir_row_t;

    typedef struct packed {
        logic [3:0] idx;
        logic       last;
    } firing_t;

    typedef struct packed {
        logic        on;
        logic [10:0] day_minute;
        logic [3:0]  rule;
    } alarm_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  sd;
        logic [3:0]  sm;
        logic [15:0] sy;
        logic [4:0]  ed;
        logic [3:0]  em;
        logic [7:0]  eo;
    } holiday_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic        cfg_wdata;
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic        entry_enable;
    logic [3:0]  day_code;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [15:0] year;
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [7:0]  end_year_offset;
    logic        result_valid;
    logic [3:0]  alarm_index;
    logic        last;

    // Predicted state of the block.
    alarm_t      alarm_tab [16];
    holiday_t    holiday_tab [16];
    logic [7:0]  seen_minute;
    logic        alarms_on_m;

    firing_t     pending_fires [$];
    int unsigned mismatches;
    int unsigned gap_pct;

    logic [4:0]  pool_hour [3];
    logic [5:0]  pool_minute [3];
    logic [4:0]  pool_mday [3];
    logic [3:0]  pool_month [3];

    weekly_alarm_matcher DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_type        (req_type),
        .slot            (slot),
        .entry_enable    (entry_enable),
        .day_code        (day_code),
        .hour            (hour),
        .minute          (minute),
        .day_of_month    (day_of_month),
        .month           (month),
        .year            (year),
        .end_day         (end_day),
        .end_month       (end_month),
        .end_year_offset (end_year_offset),
        .result_valid    (result_valid),
        .alarm_index     (alarm_index),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("weekly_alarm_matcher regression: fail");
        $finish;
    end

    // Updates the predicted state for one accepted item and, when queue_fires is set,
    // queues the alarm items it should cause. Returns 1 if the item did anything at all.
    function automatic bit apply_item(input request_t it, input bit queue_fires);
        bit          holiday_today;
        bit          fire;
        int          k;
        int          n;
        int unsigned when;
        logic [3:0]  rule;
        logic [3:0]  hits [16];
        logic [63:0] today;
        logic [63:0] lo;
        logic [63:0] hi;
        holiday_t    h;
        firing_t     f;

        if (it.req_type == REQ_ALARM)
        begin
            alarm_tab[it.slot].on = it.entry_enable;
            alarm_tab[it.slot].day_minute = 11'(int'(it.hour) * 60 + int'(it.minute));
            alarm_tab[it.slot].rule = it.day_code;
            return 1'b1;
        end
        if (it.req_type == REQ_HOLIDAY)
        begin
            holiday_tab[it.slot] = '{it.entry_enable, it.day_of_month, it.month, it.year,
                                     it.end_day, it.end_month, it.end_year_offset};
            return 1'b1;
        end
        if (it.req_type != REQ_TICK)
            return 1'b0;
        if (it.hour > LAST_HOUR || {2'b00, it.minute} == seen_minute || it.year == EPOCH_YEAR)
            return 1'b0;
        seen_minute = {2'b00, it.minute};
        if (!alarms_on_m)
            return 1'b1;

        // Dates compare as keys with the year above the month above the day.
        today = (64'(it.year) << 16) | (64'(it.month) << 8) | 64'(it.day_of_month);
        holiday_today = 1'b0;
        for (k = 0; k < 16; k++)
        begin
            h = holiday_tab[k];
            if (h.ok)
            begin
                if (it.day_of_month == h.sd && it.month == h.sm
                    && (h.sy == 16'd0 || it.year == h.sy))
                    holiday_today = 1'b1;
                if (h.ed != 5'd0 && h.em != 4'd0)
                begin
                    lo = (64'(h.sy) << 16) | (64'(h.sm) << 8) | 64'(h.sd);
                    hi = ((64'(h.sy) + 64'(h.eo)) << 16) | (64'(h.em) << 8) | 64'(h.ed);
                    if (today >= lo && today <= hi)
                        holiday_today = 1'b1;
                end
            end
        end

        n = 0;
        for (k = 0; k < 16; k++)
        begin
            when = alarm_tab[k].day_minute;
            rule = alarm_tab[k].rule;
            if (alarm_tab[k].on && when / 60 == it.hour && when % 60 == it.minute)
            begin
                if (holiday_today)
                    fire = (rule == RULE_HOLIDAY);
                else
                    fire = (rule == it.day_code) || (rule == RULE_EVERYDAY)
                        || (rule == RULE_WORKDAY && it.day_code > DAY_SUNDAY
                            && it.day_code < DAY_SATURDAY)
                        || (rule == RULE_WEEKEND && (it.day_code == DAY_SUNDAY
                            || it.day_code == DAY_SATURDAY));
                if (fire)
                begin
                    hits[n] = 4'(k);
                    n++;
                end
            end
        end
        if (queue_fires)
        begin
            for (k = 0; k < n; k++)
            begin
                f.idx = hits[k];
                f.last = (k == n - 1);
                pending_fires.push_back(f);
            end
        end
        return 1'b1;
    endfunction

    function automatic dir_row_t drow(input logic [1:0] chk, input logic [3:0] fixed_idx,
                                      input logic [1:0] rq, input logic [3:0] sl,
                                      input logic en, input logic [3:0] dc,
                                      input logic [4:0] hh, input logic [5:0] mi,
                                      input logic [4:0] md, input logic [3:0] mo,
                                      input logic [15:0] yr, input logic [4:0] ed,
                                      input logic [3:0] em, input logic [7:0] eo);
        dir_row_t r;
        r.chk = chk;
        r.fixed_idx = fixed_idx;
        r.it = '{rq, sl, en, dc, hh, mi, md, mo, yr, ed, em, eo};
        return r;
    endfunction

    function automatic dir_row_t directed(input int n);
        case (n)
            // Nothing is enabled straight after reset.
            0:  return drow(CHK_NONE, 0, REQ_TICK, 0, 0, DAY_SUNDAY, 0, 0, 1, 1, 2024, 0, 0, 0);
            1:  return drow(CHK_NONE, 0, REQ_ALARM, 0, 1, RULE_EVERYDAY, 7, 30, 0, 0, 0, 0, 0, 0);
            2:  return drow(CHK_NONE, 0, REQ_ALARM, 15, 1, RULE_WORKDAY, 7, 30, 0, 0, 0, 0, 0, 0);
            3:  return drow(CHK_NONE, 0, REQ_ALARM, 3, 1, RULE_WEEKEND, 7, 30, 0, 0, 0, 0, 0, 0);
            4:  return drow(CHK_NONE, 0, REQ_ALARM, 5, 1, 3, 7, 30, 0, 0, 0, 0, 0, 0);
            5:  return drow(CHK_NONE, 0, REQ_ALARM, 7, 1, RULE_HOLIDAY, 7, 30, 0, 0, 0, 0, 0, 0);
            6:  return drow(CHK_NONE, 0, REQ_ALARM, 9, 1, 13, 7, 30, 0, 0, 0, 0, 0, 0);
            7:  return drow(CHK_NONE, 0, REQ_ALARM, 10, 0, RULE_EVERYDAY, 7, 30, 0, 0, 0, 0, 0, 0);
            // A minute above 59 rolls into the next hour: this one rings at 6:02.
            8:  return drow(CHK_NONE, 0, REQ_ALARM, 11, 1, RULE_EVERYDAY, 5, 62, 0, 0, 0, 0, 0, 0);
            9:  return drow(CHK_NONE, 0, REQ_ALARM, 12, 1, RULE_EVERYDAY, 31, 63, 0, 0, 0, 0, 0, 0);
            10: return drow(CHK_NONE, 0, REQ_ALARM, 8, 1, RULE_HOLIDAY, 7, 31, 0, 0, 0, 0, 0, 0);
            11: return drow(CHK_MODEL, 0, REQ_TICK, 0, 0, 3, 7, 30, 6, 3, 2024, 0, 0, 0);
            // The same minute again, an invalid hour and the epoch year are all ignored.
            12: return drow(CHK_NONE, 0, REQ_TICK, 0, 0, 3, 7, 30, 6, 3, 2024, 0, 0, 0);
            13: return drow(CHK_NONE, 0, REQ_TICK, 15, 1, 15, 31, 63, 31, 15, 2024, 31, 15, 255);
            14: return drow(CHK_NONE, 0, REQ_TICK, 0, 0, 1, 7, 31, 4, 3, EPOCH_YEAR, 0, 0, 0);
            15: return drow(CHK_ONE, 11, REQ_TICK, 0, 0, DAY_SUNDAY, 6, 2, 3, 3, 2024, 0, 0, 0);
            16: return drow(CHK_MODEL, 0, REQ_TICK, 0, 0, DAY_SATURDAY, 7, 30, 9, 3, 2024, 0, 0, 0);
            17: return drow(CHK_NONE, 0, REQ_TICK, 0, 0, 15, 23, 59, 31, 15, 65535, 0, 0, 0);
            18: return drow(CHK_MODEL, 0, REQ_TICK, 0, 0, 13, 7, 30, 12, 3, 2024, 0, 0, 0);
            19: return drow(CHK_NONE, 0, REQ_HOLIDAY, 0, 1, 0, 0, 0, 25, 12, 0, 0, 0, 0);
            20: return drow(CHK_NONE, 0, REQ_HOLIDAY, 15, 1, 0, 0, 0, 20, 7, 2024, 10, 8, 0);
            21: return drow(CHK_NONE, 0, REQ_TICK, 0, 0, 2, 0, 0, 1, 1, 2030, 0, 0, 0);
            22: return drow(CHK_MODEL, 0, REQ_TICK, 0, 0, 2, 7, 30, 25, 12, 2031, 0, 0, 0);
            // Inside the summer range, so only the holiday rule rings.
            23: return drow(CHK_MODEL, 0, REQ_TICK, 0, 0, 1, 7, 31, 1, 8, 2024, 0, 0, 0);
            default:
                return drow(CHK_NONE, 0, REQ_UNUSED, 15, 1, 15, 31, 63, 31, 15, 65535, 31, 15, 255);
        endcase
    endfunction

    function automatic void refresh_pools();
        int          i;
        int unsigned base;
        base = $urandom_range(59);
        for (i = 0; i < 3; i++)
        begin
            pool_hour[i] = 5'($urandom_range(23));
            pool_minute[i] = 6'((base + 20 * i) % 60);
            pool_mday[i] = 5'($urandom_range(28, 1));
            pool_month[i] = 4'($urandom_range(12, 1));
        end
    endfunction

    function automatic logic [15:0] pool_year();
        return 16'(2023 + $urandom_range(2));
    endfunction

    // Mostly well-formed items around a few shared times and dates, so that
    // alarms and holidays actually meet the ticks; unused fields stay random.
    function automatic request_t gen_item();
        request_t    it;
        int unsigned pick;
        int unsigned p;
        int unsigned r;
        it = {$urandom, $urandom};
        pick = $urandom_range(99);
        p = $urandom_range(2);
        if (pick < 56)
        begin
            it.req_type = REQ_TICK;
            if ($urandom_range(99) < 85)
            begin
                it.hour = pool_hour[p];
                it.minute = pool_minute[p];
            end
            if ($urandom_range(99) < 70)
            begin
                it.day_of_month = pool_mday[p];
                it.month = pool_month[p];
            end
            r = $urandom_range(99);
            if (r < 3)
                it.year = EPOCH_YEAR;
            else if (r < 90)
                it.year = pool_year();
            if ($urandom_range(99) < 85)
                it.day_code = 4'($urandom_range(6));
        end
        else if (pick < 82)
        begin
            it.req_type = REQ_ALARM;
            it.entry_enable = ($urandom_range(99) < 85);
            if ($urandom_range(99) < 80)
            begin
                it.hour = pool_hour[p];
                it.minute = pool_minute[p];
            end
            if ($urandom_range(99) < 90)
                it.day_code = 4'($urandom_range(10));
        end
        else if (pick < 96)
        begin
            it.req_type = REQ_HOLIDAY;
            it.entry_enable = ($urandom_range(99) < 75);
            if ($urandom_range(99) < 75)
            begin
                it.day_of_month = pool_mday[p];
                it.month = pool_month[p];
            end
            r = $urandom_range(99);
            if (r < 40)
                it.year = 16'd0;
            else if (r < 85)
                it.year = pool_year();
            r = $urandom_range(99);
            if (r < 25)
                it.end_day = 5'd0;
            else if (r < 50)
                it.end_month = 4'd0;
            else
            begin
                it.end_day = 5'($urandom_range(31, 1));
                it.end_month = 4'($urandom_range(12, 1));
            end
            if ($urandom_range(99) < 80)
                it.end_year_offset = 8'($urandom_range(1));
        end
        else
            it.req_type = REQ_UNUSED;
        return it;
    endfunction

    // Entered and left at a falling edge; start is lowered once the item is taken.
    task automatic issue(input request_t it, input logic [1:0] chk, input logic [3:0] fixed_idx,
                         output bit effective);
        bit      taken;
        firing_t f;
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        {req_type, slot, entry_enable, day_code, hour, minute, day_of_month, month, year,
         end_day, end_month, end_year_offset} = it;
        start = 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            if (!taken)
                @(negedge clk);
        end
        effective = apply_item(it, chk == CHK_MODEL);
        if (chk == CHK_ONE)
        begin
            f.idx = fixed_idx;
            f.last = 1'b1;
            pending_fires.push_back(f);
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    // Holds the sender off until every expected item is out and the table walk is over.
    task automatic settle();
        start = 1'b0;
        while (pending_fires.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic set_alarms_on(input logic v);
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        alarms_on_m = v;
    endtask

    // Fills every alarm slot with one time and then ticks at that time.
    task automatic burst(inout int done);
        request_t   it;
        bit         eff;
        int         s;
        logic [4:0] hh;
        logic [5:0] mi;
        hh = 5'($urandom_range(23));
        mi = 6'($urandom_range(59));
        if ({2'b00, mi} == seen_minute)
            mi = (mi == 6'd59) ? 6'd0 : mi + 6'd1;
        for (s = 0; s < 16; s++)
        begin
            it = {$urandom, $urandom};
            it.req_type = REQ_ALARM;
            it.slot = 4'(s);
            it.entry_enable = ($urandom_range(9) != 0);
            it.day_code = ($urandom_range(4) != 0) ? RULE_EVERYDAY : 4'($urandom_range(10));
            it.hour = hh;
            it.minute = mi;
            issue(it, CHK_MODEL, 4'd0, eff);
            done += eff;
        end
        it = {$urandom, $urandom};
        it.req_type = REQ_TICK;
        it.hour = hh;
        it.minute = mi;
        it.year = pool_year();
        it.day_code = 4'($urandom_range(6));
        issue(it, CHK_MODEL, 4'd0, eff);
        done += eff;
    endtask

    always @(posedge clk)
    begin : result_check
        firing_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_fires.size() == 0)
            begin
                $display("%0t: unexpected alarm item, index %0d last %0b",
                         $time, alarm_index, last);
                mismatches++;
            end
            else
            begin
                want = pending_fires.pop_front();
                if (alarm_index !== want.idx)
                begin
                    $display("%0t: alarm_index expected %0d actual %0d",
                             $time, want.idx, alarm_index);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int          i;
        int          ph;
        int          done;
        int          target;
        int unsigned guard;
        bit          eff;
        dir_row_t    r;

        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        {req_type, slot, entry_enable, day_code, hour, minute, day_of_month, month, year,
         end_day, end_month, end_year_offset} = '0;
        mismatches = 0;
        gap_pct = 0;
        for (i = 0; i < 16; i++)
        begin
            alarm_tab[i] = '0;
            holiday_tab[i] = '0;
        end
        seen_minute = LAST_MINUTE_INIT;
        alarms_on_m = 1'b1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows run with the enable still at its reset value.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            r = directed(i);
            issue(r.it, r.chk, r.fixed_idx, eff);
        end

        // Targets count only items that take effect; about a fifth of the
        // random items are ignored ticks or unused requests.
        for (ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    gap_pct = 0;
                    target = 100;
                    set_alarms_on(1'b1);
                end
                1:
                begin
                    gap_pct = 65;
                    target = 45;
                    set_alarms_on(1'b0);
                end
                2:
                begin
                    gap_pct = 65;
                    target = 100;
                    set_alarms_on(1'b1);
                end
                default:
                begin
                    gap_pct = 26;
                    target = 100;
                    set_alarms_on(1'b1);
                end
            endcase
            refresh_pools();
            done = 0;
            while (done < target)
            begin
                if ($urandom_range(99) < 3)
                    burst(done);
                else
                begin
                    issue(gen_item(), CHK_MODEL, 4'd0, eff);
                    done += eff;
                end
                if ($urandom_range(99) < 2)
                    settle();
                if ($urandom_range(99) < 4)
                    refresh_pools();
            end
        end

        start = 1'b0;
        guard = 0;
        while (pending_fires.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0 && pending_fires.size() == 0)
            $display("weekly_alarm_matcher regression: pass");
        else
        begin
            if (pending_fires.size() != 0)
                $display("%0t: %0d expected alarm items never arrived, next index %0d",
                         $time, pending_fires.size(), pending_fires[0].idx);
            $display("weekly_alarm_matcher regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/wam_pkg.sv
rtl/core/wam_ctrl.sv
rtl/core/wam_datapath.sv
rtl/core/weekly_alarm_matcher.sv
tb/tb.sv
